// File: hdl/stp_seq_pkg.sv
// Shared types, codes and the full-step coil table for the stepper sequencer.
package stp_seq_pkg;

    // Request codes carried on req_type.
    localparam logic REQ_TICK = 1'b0;
    localparam logic REQ_MOVE = 1'b1;

    // Register indexes on the configuration port, one 32-bit word apart.
    localparam logic REG_STEP_PERIOD   = 1'b0;
    localparam logic REG_STEPS_PER_REV = 1'b1;

    localparam logic [31:0] STEP_PERIOD_RESET   = 32'd1000;
    localparam logic [15:0] STEPS_PER_REV_RESET = 16'd200;

    // One result as it sits in the output register.
    typedef struct packed {
        logic [3:0]  coil_pattern;
        logic [15:0] position;
        logic        stepped;
        logic        busy_res;
        logic        rejected;
    } result_t;

    // Full-step drive pattern selected by the low two bits of the position.
    function automatic logic [3:0] coil_lookup(input logic [1:0] phase);
        logic [3:0] pattern;
        case (phase)
            2'd0:    pattern = 4'b1010;
            2'd1:    pattern = 4'b0110;
            2'd2:    pattern = 4'b0101;
            2'd3:    pattern = 4'b1001;
            default: pattern = 4'b0000;
        endcase
        return pattern;
    endfunction

endpackage

// File: hdl/stepper_full_step_sequencer.sv
// Top level of the four-wire stepper motor full-step sequencer.
//
//   Channel  Direction  Handshake               Payload
//   -------  ---------  ----------------------  ----------------------------------------
//   request  in         in_valid / in_ready     req_type, step_count
//   result   out        out_valid / out_ready   coil_pattern, position, stepped,
//                                               busy_res, rejected
//   config   in         APB psel/penable/...    step_period (0x0), steps_per_rev (0x4)
//
// Each request transfer is handled in the cycle it is accepted: the motor state
// updates at that edge and the result is loaded into the output register, so one
// request per cycle is sustained. The only loop is the state registers feeding
// the tick compare, the position wrap and the coil lookup back into themselves.
// Reset (rst_n low) clears the motor state, restores the register defaults and
// empties the output register. When the result is not taken, in_ready drops and
// the held result waits; in_ready rises again in the cycle the result is taken.
module stepper_full_step_sequencer (
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 req_type,
    input  logic signed [31:0]   step_count,

    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [3:0]           coil_pattern,
    output logic [15:0]          position,
    output logic                 stepped,
    output logic                 busy_res,
    output logic                 rejected,

    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);
    import stp_seq_pkg::*;

    // Configuration registers.
    logic [31:0] step_period_reg;
    logic [15:0] steps_per_rev_reg;

    // Motor state.
    logic [31:0] elapsed_reg,   elapsed_next;
    logic [31:0] remaining_reg, remaining_next;
    logic [15:0] pos_reg,       pos_next;
    logic        forward_reg,   forward_next;
    logic [3:0]  coil_reg,      coil_next;

    // Output register.
    logic        out_valid_reg;
    result_t     result_reg, result_next;

    logic        accept;
    logic        cfg_write;
    logic        busy;
    logic        do_step;
    logic        do_reject;
    logic [31:0] elapsed_inc;
    logic [31:0] magnitude;
    logic [16:0] pos_plus;
    logic [15:0] pos_stepped;

    // The output register frees up in the same cycle its result is taken.
    assign in_ready  = !out_valid_reg || out_ready;
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;

    assign coil_pattern = result_reg.coil_pattern;
    assign position     = result_reg.position;
    assign stepped      = result_reg.stepped;
    assign busy_res     = result_reg.busy_res;
    assign rejected     = result_reg.rejected;

    // APB: no wait states; word address selects the register.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == REG_STEPS_PER_REV) ? {16'd0, steps_per_rev_reg}
                                                        : step_period_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_period_reg   <= STEP_PERIOD_RESET;
            steps_per_rev_reg <= STEPS_PER_REV_RESET;
        end
        else if (cfg_write)
        begin
            if (paddr[2] == REG_STEP_PERIOD)
            begin
                step_period_reg <= pwdata;
            end
            else
            begin
                steps_per_rev_reg <= pwdata[15:0];
            end
        end
    end

    // Step decision: the elapsed counter saturates instead of wrapping, and
    // a step needs both pending steps and a full period of ticks.
    assign busy        = (remaining_reg != 32'd0);
    assign elapsed_inc = (elapsed_reg == 32'hFFFF_FFFF) ? elapsed_reg : elapsed_reg + 32'd1;
    assign do_step     = (req_type == REQ_TICK) && busy && (elapsed_inc >= step_period_reg);
    assign do_reject   = (req_type == REQ_MOVE) && busy;

    // Two's complement magnitude; the most negative count stays 2^31.
    assign magnitude = step_count[31] ? (32'd0 - step_count) : step_count;

    // Next position with wrap-around in either direction. A position left
    // beyond the revolution by a register change wraps like position zero
    // going backward and like the end of the revolution going forward.
    assign pos_plus = {1'b0, pos_reg} + 17'd1;

    always_comb
    begin
        if (steps_per_rev_reg == 16'd0)
        begin
            pos_stepped = 16'd0;
        end
        else if (forward_reg)
        begin
            pos_stepped = (pos_plus >= {1'b0, steps_per_rev_reg}) ? 16'd0 : pos_plus[15:0];
        end
        else if ((pos_reg == 16'd0) || (pos_reg >= steps_per_rev_reg))
        begin
            pos_stepped = steps_per_rev_reg - 16'd1;
        end
        else
        begin
            pos_stepped = pos_reg - 16'd1;
        end
    end

    always_comb
    begin
        elapsed_next   = elapsed_reg;
        remaining_next = remaining_reg;
        pos_next       = pos_reg;
        forward_next   = forward_reg;
        coil_next      = coil_reg;

        if (req_type == REQ_MOVE)
        begin
            // A move while busy changes nothing; a zero count keeps direction.
            if (!busy && (step_count != 32'sd0))
            begin
                forward_next   = !step_count[31];
                remaining_next = magnitude;
            end
        end
        else
        begin
            elapsed_next = elapsed_inc;
            if (do_step)
            begin
                pos_next       = pos_stepped;
                coil_next      = coil_lookup(pos_stepped[1:0]);
                elapsed_next   = 32'd0;
                remaining_next = remaining_reg - 32'd1;
            end
        end

        result_next.coil_pattern = coil_next;
        result_next.position     = pos_next;
        result_next.stepped      = do_step;
        result_next.busy_res     = (remaining_next != 32'd0);
        result_next.rejected     = do_reject;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            elapsed_reg   <= 32'd0;
            remaining_reg <= 32'd0;
            pos_reg       <= 16'd0;
            forward_reg   <= 1'b0;
            coil_reg      <= 4'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                elapsed_reg   <= elapsed_next;
                remaining_reg <= remaining_next;
                pos_reg       <= pos_next;
                forward_reg   <= forward_next;
                coil_reg      <= coil_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            result_reg <= result_next;
        end
    end

    // An accepted request always leaves a result waiting in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> out_valid)
        else $error("accepted request produced no result");

    // A rejected move leaves the pending steps in place.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && rejected) |-> (busy_res && !stepped))
        else $error("rejected move reported without pending steps");

    // After a step the coils always carry a drive pattern.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && stepped) |-> (coil_pattern != 4'd0))
        else $error("step reported with all coils low");

endmodule

// File: tb/stepper_full_step_sequencer_test.sv
// Self-checking testbench for the four-wire stepper full-step sequencer.
`timescale 1ns / 1ps

module stepper_full_step_sequencer_test;
    import stp_seq_pkg::*;

    // A transfer on either channel resets the watchdog; a long quiet stretch ends the run.
    localparam int WATCHDOG_LIMIT   = 4000;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int ITEMS_PER_PHASE  = 160;
    localparam int MAX_REPORTS      = 10;

    // Predicts the motor state for every accepted request and checks each result
    // against the oldest prediction.
    class motion_scoreboard;
        logic [31:0] period_ticks;
        logic [15:0] rev_positions;
        logic [31:0] tick_count;
        logic [31:0] pending_steps;
        logic [15:0] shaft_pos;
        logic        moving_forward;
        logic [3:0]  coil_drive;
        result_t     expected_q[$];
        int          result_index;
        int          failures;

        function new();
            period_ticks   = STEP_PERIOD_RESET;
            rev_positions  = STEPS_PER_REV_RESET;
            tick_count     = '0;
            pending_steps  = '0;
            shaft_pos      = '0;
            moving_forward = 1'b0;
            coil_drive     = '0;
            result_index   = 0;
            failures       = 0;
        endfunction

        function void set_register(input logic index, input logic [31:0] value);
            if (index == REG_STEP_PERIOD)
                period_ticks = value;
            else
                rev_positions = value[15:0];
        endfunction

        function void note_request(input logic kind, input logic [31:0] count);
            result_t     want;
            logic [16:0] next_pos;
            want = '0;
            if (kind == REQ_MOVE)
            begin
                if (pending_steps != 0)
                    want.rejected = 1'b1;
                else if (count != 0)
                begin
                    moving_forward = !count[31];
                    pending_steps  = count[31] ? 32'd0 - count : count;
                end
            end
            else
            begin
                if (tick_count != 32'hFFFF_FFFF)
                    tick_count = tick_count + 32'd1;
                if (pending_steps != 0 && tick_count >= period_ticks)
                begin
                    if (rev_positions == 0)
                        shaft_pos = '0;
                    else if (moving_forward)
                    begin
                        next_pos = {1'b0, shaft_pos} + 17'd1;
                        shaft_pos = (next_pos >= {1'b0, rev_positions}) ? 16'd0 : next_pos[15:0];
                    end
                    else if (shaft_pos == 0 || shaft_pos >= rev_positions)
                        shaft_pos = rev_positions - 16'd1;
                    else
                        shaft_pos = shaft_pos - 16'd1;
                    case (shaft_pos[1:0])
                        2'd0:    coil_drive = 4'b1010;
                        2'd1:    coil_drive = 4'b0110;
                        2'd2:    coil_drive = 4'b0101;
                        default: coil_drive = 4'b1001;
                    endcase
                    tick_count    = '0;
                    pending_steps = pending_steps - 32'd1;
                    want.stepped  = 1'b1;
                end
            end
            want.coil_pattern = coil_drive;
            want.position     = shaft_pos;
            want.busy_res     = (pending_steps != 0);
            expected_q.push_back(want);
        endfunction

        function void check_result(input logic [3:0] coils, input logic [15:0] pos,
                                   input logic did_step, input logic busy,
                                   input logic refused);
            result_t want;
            if (expected_q.size() == 0)
            begin
                failures++;
                if (failures <= MAX_REPORTS)
                    $display("ERROR: result %0d arrived with nothing expected", result_index);
            end
            else
            begin
                want = expected_q.pop_front();
                if (coils !== want.coil_pattern || pos !== want.position ||
                    did_step !== want.stepped || busy !== want.busy_res ||
                    refused !== want.rejected)
                begin
                    failures++;
                    if (failures <= MAX_REPORTS)
                        $display({"ERROR: result %0d expected coils=%b pos=%0d stepped=%b ",
                                  "busy=%b rejected=%b, got coils=%b pos=%0d stepped=%b ",
                                  "busy=%b rejected=%b"}, result_index,
                                 want.coil_pattern, want.position, want.stepped,
                                 want.busy_res, want.rejected,
                                 coils, pos, did_step, busy, refused);
                end
            end
            result_index++;
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic               req_type;
    logic signed [31:0] step_count;
    logic               out_valid;
    logic               out_ready;
    logic [3:0]         coil_pattern;
    logic [15:0]        position;
    logic               stepped;
    logic               busy_res;
    logic               rejected;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [2:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    motion_scoreboard sb;

    // Random idling on both channels is switched off for the closing part of the run.
    bit idle_on;
    // Raised by the stimulus to make the result side hold off for a long stretch.
    bit hold_request;
    int items_sent;
    int idle_cycles;

    stepper_full_step_sequencer i_dut (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Both channels are sampled at the rising edge, before any nonblocking update of
    // that edge lands, so a transfer is seen exactly when the block sees it.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
                sb.check_result(coil_pattern, position, stepped, busy_res, rejected);
            if (in_valid && in_ready)
                sb.note_request(req_type, step_count);
        end
    end

    // Offers one request and returns at the edge where it is transferred. Valid is left
    // high so that the next call can follow back to back without a bubble.
    task send_item(input logic kind, input logic [31:0] count);
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        in_valid   <= 1'b1;
        req_type   <= kind;
        step_count <= count;
        do
            @(posedge clk);
        while (!in_ready);
        items_sent++;
    endtask

    // Ticks carry random payload: the count must be ignored on a tick.
    task send_tick();
        send_item(REQ_TICK, $urandom());
    endtask

    // Stops offering requests and waits until every predicted result has come back.
    // The first edge lets the monitor note the last transfer before the queue is read.
    task drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.expected_q.size() != 0)
            @(posedge clk);
    endtask

    // APB write: setup cycle, then access cycle; the register takes the data at the
    // edge where psel, penable, pwrite and pready are all seen high.
    task write_register(input logic index, input logic [31:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.set_register(index, value);
    endtask

    // One move with a short count followed by the ticks needed to finish it. Some
    // sequences are cut short, some carry commands that arrive while the motor is
    // still busy. A random full-width count is only sent right after a move, where
    // the motor is certain to be busy, so it is always turned away and never loads
    // a count that could not be worked off.
    task run_move_sequence();
        int          magnitude;
        int          tick_total;
        logic [31:0] count;
        magnitude = $urandom_range(1, 6);
        count = $urandom_range(0, 1) ? 32'(magnitude) : 32'd0 - 32'(magnitude);
        if ($urandom_range(0, 19) == 0)
            count = '0;
        send_item(REQ_MOVE, count);
        if (count != 0 && $urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 2)) send_item(REQ_MOVE, $urandom());
        tick_total = magnitude * (int'(sb.period_ticks) + 1);
        if ($urandom_range(0, 4) == 0)
            tick_total = $urandom_range(0, tick_total);
        repeat (tick_total)
        begin
            if ($urandom_range(0, 9) == 0)
                send_item(REQ_MOVE, $urandom_range(0, 1) ? 32'd3 : 32'hFFFF_FFFD);
            send_tick();
        end
    endtask

    task run_phase(input logic [31:0] period, input logic [15:0] positions,
                   input bit with_hold);
        int target;
        write_register(REG_STEP_PERIOD, period);
        write_register(REG_STEPS_PER_REV, {16'd0, positions});
        target = items_sent + ITEMS_PER_PHASE;
        while (items_sent < target)
        begin
            // Halfway through, the result side stops while requests keep coming.
            if (with_hold && items_sent > target - ITEMS_PER_PHASE / 2)
            begin
                hold_request = 1'b1;
                with_hold    = 1'b0;
            end
            if ($urandom_range(0, 9) < 8)
                run_move_sequence();
            else if ($urandom_range(0, 1) == 0)
                repeat ($urandom_range(1, 6)) send_tick();
            else
                send_item(REQ_MOVE, $urandom_range(0, 1) ? 32'd2 : 32'hFFFF_FFFE);
        end
        drain();
    endtask

    // Result side: short random stalls, runs of steady acceptance, and one long
    // hold-off when the stimulus asks for it.
    initial
    begin
        out_ready <= 1'b0;
        @(posedge clk);
        forever
        begin
            if (hold_request)
            begin
                hold_request = 1'b0;
                out_ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge clk);
            end
            else if (idle_on && $urandom_range(0, 4) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end
            else
            begin
                out_ready <= 1'b1;
                repeat ($urandom_range(1, 16)) @(posedge clk);
            end
        end
    end

    initial
    begin
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("ERROR: no transfer for %0d cycles", WATCHDOG_LIMIT);
        $display("Mismatches found");
        $finish;
    end

    initial
    begin
        sb           = new();
        idle_on      = 1'b1;
        hold_request = 1'b0;
        items_sent   = 0;
        rst_n      <= 1'b0;
        in_valid   <= 1'b0;
        req_type   <= REQ_TICK;
        step_count <= '0;
        psel       <= 1'b0;
        penable    <= 1'b0;
        pwrite     <= 1'b0;
        paddr      <= '0;
        pwdata     <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, at the reset settings: the coils stay low before any step,
        // a zero count does nothing, and a command while busy is turned away.
        send_tick();
        send_item(REQ_MOVE, 32'd0);
        send_item(REQ_MOVE, 32'hFFFF_FFFF);
        send_item(REQ_MOVE, 32'h7FFF_FFFF);
        send_tick();
        drain();

        // A zero period steps on every tick while busy; the pending backward step
        // wraps from position 0 to the top of the revolution, then forward wraps to 0.
        write_register(REG_STEP_PERIOD, 32'd0);
        send_tick();
        send_item(REQ_MOVE, 32'd2);
        send_tick();
        send_tick();
        drain();

        // Largest revolution: backward from 0 lands on its last position.
        write_register(REG_STEPS_PER_REV, 32'd65535);
        send_item(REQ_MOVE, 32'hFFFF_FFFE);
        send_tick();
        send_tick();
        drain();

        // Shrinking the revolution leaves the position beyond it: a forward step
        // wraps to 0, and a backward step from 0 lands on the last position.
        write_register(REG_STEPS_PER_REV, 32'd10);
        send_item(REQ_MOVE, 32'd1);
        send_tick();
        send_item(REQ_MOVE, 32'hFFFF_FFFF);
        send_tick();
        drain();

        // Backward from a position beyond the revolution lands on its last position.
        write_register(REG_STEPS_PER_REV, 32'd4);
        send_item(REQ_MOVE, 32'hFFFF_FFFF);
        send_tick();
        drain();

        // A zero revolution holds the position at 0 and still drives the coils.
        write_register(REG_STEPS_PER_REV, 32'd0);
        send_item(REQ_MOVE, 32'd1);
        send_tick();
        drain();

        // A single-position revolution with a two-tick period.
        write_register(REG_STEPS_PER_REV, 32'd1);
        write_register(REG_STEP_PERIOD, 32'd2);
        send_item(REQ_MOVE, 32'hFFFF_FFFF);
        send_tick();
        send_tick();
        send_tick();
        drain();

        // Random part over a spread of settings.
        run_phase(32'd1, 16'd200, 1'b0);
        run_phase(32'd0, 16'd7, 1'b0);
        run_phase(32'd2, 16'd4, 1'b1);
        run_phase(32'd3, 16'd65535, 1'b0);
        run_phase(32'd1, 16'd1, 1'b0);
        run_phase(32'd4, 16'd13, 1'b0);
        run_phase(32'd0, 16'd3, 1'b0);
        run_phase(32'd2, 16'd50, 1'b0);

        // Closing part without idling. The most negative count loads 2^31 steps that
        // the largest period does not let run here, so each later command is turned away.
        idle_on = 1'b0;
        write_register(REG_STEP_PERIOD, 32'hFFFF_FFFF);
        write_register(REG_STEPS_PER_REV, 32'd65535);
        send_item(REQ_MOVE, 32'h8000_0000);
        send_item(REQ_MOVE, 32'h7FFF_FFFF);
        repeat (80)
        begin
            if ($urandom_range(0, 2) == 0)
                send_item(REQ_MOVE, $urandom());
            else
                send_tick();
        end
        drain();
        repeat (10) @(posedge clk);

        if (sb.failures == 0 && sb.expected_q.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// File: stepper_full_step_sequencer.f
hdl/stp_seq_pkg.sv
hdl/stepper_full_step_sequencer.sv
tb/stepper_full_step_sequencer_test.sv
